// File: hdl/cst_pkg.sv
// package for the counting semaphore table
// constants, codes and the front-to-back request type; no dependencies
package cst_pkg;

    localparam int NUM_SEMS   = 16;
    localparam int WAIT_DEPTH = 8;
    localparam int SLOT_W     = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
    localparam int STK_W      = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int FILL_W     = $clog2(WAIT_DEPTH + 1);
    localparam int STK_ADDR_W = SLOT_W + STK_W;
    localparam int STK_DEPTH  = NUM_SEMS * WAIT_DEPTH;
    localparam int QDEPTH     = 2;

    // byte address of the enable register
    localparam logic [1:0] REG_ENABLE = 2'd0;

    localparam logic [2:0] FN_INIT   = 3'd0;
    localparam logic [2:0] FN_SIGNAL = 3'd1;
    localparam logic [2:0] FN_WAIT   = 3'd2;
    localparam logic [2:0] FN_FREE   = 3'd3;
    localparam logic [2:0] FN_TICK   = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BLOCKED  = 3'd1;
    localparam logic [2:0] ST_ERROR    = 3'd2;
    localparam logic [2:0] ST_RELEASED = 3'd3;
    localparam logic [2:0] ST_TICKDONE = 3'd4;

    // kind of work handed to the back part
    typedef enum logic [1:0] {
        OP_ERROR,
        OP_INIT,
        OP_LOOKUP,
        OP_TICK
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [2:0]  func;
        logic [15:0] sem_id;
        logic [15:0] init_count;
        logic [7:0]  task_id;
    } req_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SCAN,
        BK_EXEC,
        BK_POP,
        BK_EMIT
    } bk_state_t;

endpackage

// File: hdl/cst_front.sv
// front part: accepts and classifies requests, queues them for the back part
// depends on cst_pkg
module cst_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                enable,
    input  logic                push,
    output logic                full,
    input  logic [2:0]          func,
    input  logic [15:0]         sem_id,
    input  logic [15:0]         init_count,
    input  logic [7:0]          task_id,
    output logic                q_valid,
    output cst_pkg::req_t       q_data,
    input  logic                q_take
);

    cst_pkg::req_t q_reg [cst_pkg::QDEPTH];
    logic          wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0]    cnt_reg, cnt_next;
    cst_pkg::req_t req;
    logic          do_push, do_pop;

    always_comb
    begin
        req.func          = func;
        req.sem_id        = sem_id;
        req.init_count    = init_count;
        req.task_id       = task_id;
        if (!enable)
            req.op = cst_pkg::OP_ERROR;
        else
        begin
            unique case (func)
                cst_pkg::FN_INIT:  req.op = cst_pkg::OP_INIT;
                cst_pkg::FN_SIGNAL, cst_pkg::FN_WAIT, cst_pkg::FN_FREE:
                    req.op = (sem_id == 16'd0) ? cst_pkg::OP_ERROR : cst_pkg::OP_LOOKUP;
                cst_pkg::FN_TICK:  req.op = cst_pkg::OP_TICK;
                default:           req.op = cst_pkg::OP_ERROR;
            endcase
        end
    end

    assign full    = (cnt_reg == 2'(cst_pkg::QDEPTH));
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data  = q_reg[rp_reg];
    assign do_push = push && !full;
    assign do_pop  = q_take && q_valid;

    always_comb
    begin
        wp_next  = do_push ? ~wp_reg : wp_reg;
        rp_next  = do_pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            q_reg[wp_reg] <= req;
    end

endmodule

// File: hdl/cst_back.sv
// back part: walks the slot table, executes commands and emits results
// depends on cst_pkg
module cst_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                clear,
    input  logic                q_valid,
    input  cst_pkg::req_t       q_data,
    output logic                q_take,
    output logic                res_valid,
    input  logic                res_take,
    output logic [2:0]          res_status,
    output logic [15:0]         res_id,
    output logic [7:0]          res_task,
    output logic                res_last
);

    localparam logic [cst_pkg::SLOT_W-1:0] LAST_SLOT = cst_pkg::SLOT_W'(cst_pkg::NUM_SEMS - 1);

    logic [cst_pkg::NUM_SEMS-1:0] used_reg;
    logic [15:0] ident_reg   [cst_pkg::NUM_SEMS];
    logic [15:0] count_reg   [cst_pkg::NUM_SEMS];
    logic [15:0] initial_reg [cst_pkg::NUM_SEMS];
    logic [cst_pkg::FILL_W-1:0] fill_reg [cst_pkg::NUM_SEMS];
    logic [7:0]  stack_mem [cst_pkg::STK_DEPTH];
    logic [7:0]  stack_rd_reg;
    logic [15:0] next_ident_reg;

    cst_pkg::bk_state_t state_reg, state_next;
    cst_pkg::req_t      cur_reg;
    logic [cst_pkg::SLOT_W-1:0] idx_reg, idx_next;
    logic        found_reg, found_next;
    logic [cst_pkg::SLOT_W-1:0] hit_reg, hit_next;

    logic        ov_reg;
    logic [2:0]  o_status_reg;
    logic [15:0] o_id_reg;
    logic [7:0]  o_task_reg;
    logic        o_last_reg;

    logic        emit;
    logic [2:0]  e_status;
    logic [15:0] e_id;
    logic [7:0]  e_task;
    logic        e_last;

    logic        stk_we, stk_re;
    logic [cst_pkg::STK_ADDR_W-1:0] stk_waddr, stk_raddr;

    logic        wr_init, wr_signal, wr_wait_dec, wr_wait_push, wr_free, wr_tick;
    logic        slot_match, slot_free, slot_rel;
    logic [cst_pkg::SLOT_W-1:0] s;

    assign res_valid  = ov_reg;
    assign res_status = o_status_reg;
    assign res_id     = o_id_reg;
    assign res_task   = o_task_reg;
    assign res_last   = o_last_reg;

    assign slot_match = used_reg[idx_reg] && (ident_reg[idx_reg] == cur_reg.sem_id);
    assign slot_free  = !used_reg[idx_reg];
    assign slot_rel   = used_reg[idx_reg] && (count_reg[idx_reg] != 16'd0)
                        && (fill_reg[idx_reg] != '0);
    assign s          = hit_reg;

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        found_next  = found_reg;
        hit_next    = hit_reg;
        q_take      = 1'b0;
        emit        = 1'b0;
        e_status    = cst_pkg::ST_ERROR;
        e_id        = 16'd0;
        e_task      = 8'd0;
        e_last      = 1'b1;
        stk_re      = 1'b0;
        stk_raddr   = {idx_reg, cst_pkg::STK_W'(fill_reg[idx_reg] - 1'b1)};
        wr_init     = 1'b0;
        wr_signal   = 1'b0;
        wr_wait_dec = 1'b0;
        wr_wait_push = 1'b0;
        wr_free     = 1'b0;
        wr_tick     = 1'b0;
        unique case (state_reg)
            cst_pkg::BK_IDLE:
            begin
                if (q_valid && !ov_reg)
                begin
                    q_take = 1'b1;
                    idx_next = '0;
                    found_next = 1'b0;
                    if (q_data.op == cst_pkg::OP_ERROR)
                        emit = 1'b1;
                    else
                        state_next = cst_pkg::BK_SCAN;
                end
            end
            cst_pkg::BK_SCAN:
            begin
                // one slot per cycle; a tick scan waits while a result is held
                if (cur_reg.op == cst_pkg::OP_TICK)
                begin
                    if (!ov_reg)
                    begin
                        if (slot_rel)
                        begin
                            stk_re = 1'b1;
                            hit_next = idx_reg;
                            wr_tick = 1'b1;
                            state_next = cst_pkg::BK_POP;
                        end
                        else if (idx_reg == LAST_SLOT)
                        begin
                            emit = 1'b1;
                            e_status = cst_pkg::ST_TICKDONE;
                            state_next = cst_pkg::BK_IDLE;
                        end
                        else
                            idx_next = idx_reg + 1'b1;
                    end
                end
                else
                begin
                    if (!found_reg && ((cur_reg.op == cst_pkg::OP_INIT) ? slot_free : slot_match))
                    begin
                        found_next = 1'b1;
                        hit_next = idx_reg;
                    end
                    if (idx_reg == LAST_SLOT)
                        state_next = cst_pkg::BK_EXEC;
                    else
                        idx_next = idx_reg + 1'b1;
                end
            end
            cst_pkg::BK_POP:
                state_next = cst_pkg::BK_EMIT;
            cst_pkg::BK_EMIT:
            begin
                emit = 1'b1;
                e_status = cst_pkg::ST_RELEASED;
                e_id = ident_reg[s];
                e_task = stack_rd_reg;
                e_last = 1'b0;
                if (idx_reg == LAST_SLOT)
                    state_next = cst_pkg::BK_SCAN;
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    state_next = cst_pkg::BK_SCAN;
                end
                // past the last slot still needs the done item
                if (idx_reg == LAST_SLOT)
                    found_next = 1'b1;
            end
            cst_pkg::BK_EXEC:
            begin
                if (!ov_reg)
                begin
                    emit = 1'b1;
                    state_next = cst_pkg::BK_IDLE;
                    if (found_reg)
                    begin
                        case (cur_reg.func)
                            cst_pkg::FN_INIT:
                                if (next_ident_reg != 16'd0)
                                begin
                                    wr_init = 1'b1;
                                    e_status = cst_pkg::ST_OK;
                                    e_id = next_ident_reg;
                                end
                            cst_pkg::FN_SIGNAL:
                            begin
                                wr_signal = 1'b1;
                                e_status = cst_pkg::ST_OK;
                                e_id = ident_reg[s];
                            end
                            cst_pkg::FN_WAIT:
                                if (count_reg[s] != 16'd0)
                                begin
                                    wr_wait_dec = 1'b1;
                                    e_status = cst_pkg::ST_OK;
                                    e_id = ident_reg[s];
                                end
                                else if (fill_reg[s] < cst_pkg::FILL_W'(cst_pkg::WAIT_DEPTH))
                                begin
                                    wr_wait_push = 1'b1;
                                    e_status = cst_pkg::ST_BLOCKED;
                                    e_id = ident_reg[s];
                                end
                            cst_pkg::FN_FREE:
                                if (count_reg[s] == initial_reg[s] && fill_reg[s] == '0)
                                begin
                                    wr_free = 1'b1;
                                    e_status = cst_pkg::ST_OK;
                                    e_id = ident_reg[s];
                                end
                            default: ;
                        endcase
                    end
                end
            end
            default: state_next = cst_pkg::BK_IDLE;
        endcase
        // tick finished on the last slot after a release
        if (state_reg == cst_pkg::BK_SCAN && cur_reg.op == cst_pkg::OP_TICK && found_reg
            && !ov_reg)
        begin
            emit = 1'b1;
            e_status = cst_pkg::ST_TICKDONE;
            e_id = 16'd0;
            e_task = 8'd0;
            e_last = 1'b1;
            stk_re = 1'b0;
            wr_tick = 1'b0;
            idx_next = idx_reg;
            state_next = cst_pkg::BK_IDLE;
        end
    end

    assign stk_we    = wr_wait_push;
    assign stk_waddr = {s, cst_pkg::STK_W'(fill_reg[s])};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= cst_pkg::BK_IDLE;
            ov_reg         <= 1'b0;
            used_reg       <= '0;
            next_ident_reg <= 16'd1;
            idx_reg        <= '0;
            found_reg      <= 1'b0;
            hit_reg        <= '0;
            for (int i = 0; i < cst_pkg::NUM_SEMS; i++)
                fill_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            found_reg <= found_next;
            hit_reg   <= hit_next;
            if (emit)
                ov_reg <= 1'b1;
            else if (res_take)
                ov_reg <= 1'b0;
            if (clear)
            begin
                used_reg <= '0;
                for (int i = 0; i < cst_pkg::NUM_SEMS; i++)
                    fill_reg[i] <= '0;
            end
            else
            begin
                if (wr_init)
                begin
                    used_reg[s]    <= 1'b1;
                    fill_reg[s]    <= '0;
                    next_ident_reg <= next_ident_reg + 16'd1;
                end
                if (wr_free)
                    used_reg[s] <= 1'b0;
                if (wr_wait_push)
                    fill_reg[s] <= fill_reg[s] + 1'b1;
                if (wr_tick)
                    fill_reg[idx_reg] <= fill_reg[idx_reg] - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == cst_pkg::BK_IDLE && q_take)
            cur_reg <= q_data;
        if (wr_init)
        begin
            ident_reg[s]   <= next_ident_reg;
            count_reg[s]   <= cur_reg.init_count;
            initial_reg[s] <= cur_reg.init_count;
        end
        if (wr_signal && count_reg[s] < initial_reg[s])
            count_reg[s] <= count_reg[s] + 16'd1;
        if (wr_wait_dec)
            count_reg[s] <= count_reg[s] - 16'd1;
        if (wr_tick)
            count_reg[idx_reg] <= count_reg[idx_reg] - 16'd1;
        if (stk_we)
            stack_mem[stk_waddr] <= cur_reg.task_id;
        if (stk_re)
            stack_rd_reg <= stack_mem[stk_raddr];
        if (emit)
        begin
            o_status_reg <= e_status;
            o_id_reg     <= e_id;
            o_task_reg   <= e_task;
            o_last_reg   <= e_last;
        end
    end

endmodule

// File: hdl/cst_regs.sv
// configuration register file, APB-style write and read
// depends on cst_pkg for the register address
module cst_regs
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic        enable,
    output logic        clear
);

    logic enable_reg, enable_next;
    logic wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && (paddr == cst_pkg::REG_ENABLE);
    assign clear  = wr && pwdata[0];
    assign enable = enable_reg;
    assign prdata = (paddr == cst_pkg::REG_ENABLE) ? {31'd0, enable_reg} : 32'd0;

    always_comb
        enable_next = wr ? pwdata[0] : enable_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            enable_reg <= 1'b0;
        else
            enable_reg <= enable_next;
    end

endmodule

// File: hdl/counting_semaphore_table.sv
// top level of the counting semaphore table: joins registers, front and back
// depends on cst_pkg, cst_regs, cst_front, cst_back
// A request is classified on entry and queued two deep; the back part then
// walks all 16 slots one per cycle, a tick scan pausing while a result is
// held. A command answers after the full scan, a refused request without
// one; a tick emits an item per released task, read through the registered
// read of the waiter stack memory, and a done item past the last slot.
// Results wait in a one-deep output register and the back part takes no
// request and emits nothing while it is held. Writing enable with 1 empties
// the table at once.
module counting_semaphore_table
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  func,
    input  logic [15:0] sem_id,
    input  logic [15:0] init_count,
    input  logic [7:0]  task_id,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  status,
    output logic [15:0] result_id,
    output logic [7:0]  released_task,
    output logic        last
);

    logic          enable, clear, q_valid, q_take, res_valid;
    cst_pkg::req_t q_data;

    cst_regs u_regs (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .enable(enable), .clear(clear)
    );

    cst_front u_front (
        .clk(clk), .rst_n(rst_n), .enable(enable), .push(push), .full(full),
        .func(func), .sem_id(sem_id), .init_count(init_count), .task_id(task_id),
        .q_valid(q_valid), .q_data(q_data), .q_take(q_take)
    );

    cst_back u_back (
        .clk(clk), .rst_n(rst_n), .clear(clear), .q_valid(q_valid), .q_data(q_data),
        .q_take(q_take), .res_valid(res_valid), .res_take(pop),
        .res_status(status), .res_id(result_id), .res_task(released_task),
        .res_last(last)
    );

    assign empty = !res_valid;

endmodule

// File: hdl/cst_checker.sv
// port-level checker for the counting semaphore table, bound to the top level
// depends on cst_pkg
module cst_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [2:0]  status,
    input logic [15:0] result_id,
    input logic [7:0]  released_task,
    input logic        last
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(status) && $stable(result_id)))
        else $error("result changed while stalled");

    a_err_id: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (status == cst_pkg::ST_ERROR || status == cst_pkg::ST_TICKDONE))
        |-> (result_id == 16'd0 && last))
        else $error("error or tick done with id or without last");

    a_rel: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status == cst_pkg::ST_RELEASED) |-> (!last && result_id != 16'd0))
        else $error("released item malformed");

    a_task: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status != cst_pkg::ST_RELEASED) |-> (released_task == 8'd0))
        else $error("task set on non-release item");

endmodule

bind counting_semaphore_table cst_checker u_cst_checker (
    .clk(clk), .rst_n(rst_n), .empty(empty), .pop(pop), .status(status),
    .result_id(result_id), .released_task(released_task), .last(last)
);
